FILE: hdl/ean8_pkg.sv
// Shared types, constants and lookup functions of the EAN-8 row scanner.
// Used by every module of the block; depends on nothing.
package ean8_pkg;

	localparam int MAX_MODULE_WIDTH = 15;
	localparam int CNT_W            = $clog2(MAX_MODULE_WIDTH + 1);
	localparam int LEAD_W           = 8;
	localparam int IDX_W            = 7;
	localparam int PAT_W            = 7;
	localparam int POS_W            = 3;
	localparam int DIGIT_W          = 4;
	localparam int NUM_DIGITS       = 10;
	localparam int HALF_DIGITS      = 4;

	localparam int LEFT_START    = 3;
	localparam int RIGHT_START   = 36;
	localparam int DIGIT_MODULES = 7;

	localparam logic [CNT_W-1:0]  RST_MODULE_WIDTH = CNT_W'(3);
	localparam logic [LEAD_W-1:0] RST_LEAD_PIXELS  = LEAD_W'(3);
	localparam logic [IDX_W-1:0]  IDX_MAX          = '1;
	localparam logic [POS_W-1:0]  POS_LAST         = '1;

	// Register indexes on the configuration port.
	localparam logic REG_MODULE_WIDTH = 1'b0;
	localparam logic REG_LEAD_PIXELS  = 1'b1;

	typedef logic [PAT_W-1:0] pat_t;

	// L-code and R-code patterns, first module in the most significant bit.
	localparam pat_t L_TABLE [NUM_DIGITS] = '{
		7'h0D, 7'h19, 7'h13, 7'h3D, 7'h23, 7'h31, 7'h2F, 7'h3B, 7'h37, 7'h0B
	};
	localparam pat_t R_TABLE [NUM_DIGITS] = '{
		7'h72, 7'h66, 7'h6C, 7'h42, 7'h5C, 7'h4E, 7'h50, 7'h44, 7'h48, 7'h74
	};

	// One finished digit window, handed from the framer to the decoder.
	typedef struct packed {
		pat_t             pattern;
		logic [POS_W-1:0] position;
	} evt_t;

	typedef struct packed {
		logic             hit;
		logic [POS_W-1:0] position;
	} win_t;

	typedef struct packed {
		logic               matched;
		logic [DIGIT_W-1:0] digit;
	} dec_t;

	// Tells whether module k is the seventh module of a digit window.
	function automatic win_t digit_end(input logic [IDX_W-1:0] k);
		win_t r;
		r = '0;
		for (int i = 0; i < HALF_DIGITS; i++) begin
			if (k == IDX_W'(LEFT_START + i * DIGIT_MODULES + DIGIT_MODULES - 1)) begin
				r.hit      = 1'b1;
				r.position = POS_W'(i);
			end
			if (k == IDX_W'(RIGHT_START + i * DIGIT_MODULES + DIGIT_MODULES - 1)) begin
				r.hit      = 1'b1;
				r.position = POS_W'(HALF_DIGITS + i);
			end
		end
		return r;
	endfunction

	// Matches a pattern against the L or R table; the lowest digit wins.
	function automatic dec_t lookup(input pat_t pat, input logic right_half);
		dec_t r;
		pat_t entry;
		r = '0;
		for (int j = NUM_DIGITS - 1; j >= 0; j--) begin
			entry = right_half ? R_TABLE[j] : L_TABLE[j];
			if (entry == pat) begin
				r.matched = 1'b1;
				r.digit   = DIGIT_W'(j);
			end
		end
		return r;
	endfunction

endpackage

FILE: hdl/ean8_apb_regs.sv
// APB-style configuration registers: module width and lead pixel count.
// Depends on ean8_pkg.
module ean8_apb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output logic [ean8_pkg::CNT_W-1:0]   module_width,
	output logic [ean8_pkg::LEAD_W-1:0]  lead_pixels
);

	logic                        wr_en;
	logic [ean8_pkg::CNT_W-1:0]  width_q;
	logic [ean8_pkg::LEAD_W-1:0] lead_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= ean8_pkg::RST_MODULE_WIDTH;
			lead_q  <= ean8_pkg::RST_LEAD_PIXELS;
		end else if (wr_en) begin
			if (paddr[2] == ean8_pkg::REG_MODULE_WIDTH) begin
				width_q <= pwdata[ean8_pkg::CNT_W-1:0];
			end else begin
				lead_q <= pwdata[ean8_pkg::LEAD_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == ean8_pkg::REG_MODULE_WIDTH) begin
			prdata = 32'(width_q);
		end else begin
			prdata = 32'(lead_q);
		end
	end

	assign module_width = width_q;
	assign lead_pixels  = lead_q;

endmodule

FILE: hdl/ean8_module_framer.sv
// Row counters: lead skip, per-module majority vote and digit window tracking.
// Holds a finished window in a stage register. Depends on ean8_pkg.
module ean8_module_framer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [ean8_pkg::CNT_W-1:0]   module_width,
	input  logic [ean8_pkg::LEAD_W-1:0]  lead_pixels,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         pixel,
	input  logic                         row_end,
	output logic                         evt_valid,
	input  logic                         evt_ready,
	output ean8_pkg::evt_t               evt
);

	logic [ean8_pkg::LEAD_W-1:0] lead_count_q;
	logic [ean8_pkg::CNT_W-1:0]  pim_q;
	logic [ean8_pkg::CNT_W-1:0]  sum_q;
	logic [ean8_pkg::IDX_W-1:0]  index_q;
	ean8_pkg::pat_t              pat_q;
	logic                        valid_s1;
	ean8_pkg::evt_t              evt_s1;

	logic                        accept;
	logic [ean8_pkg::CNT_W-1:0]  w;
	logic                        in_lead;
	logic [ean8_pkg::CNT_W-1:0]  sum_nx;
	logic [ean8_pkg::CNT_W-1:0]  pim_nx;
	logic                        mod_done;
	logic                        mod_bit;
	ean8_pkg::pat_t              pat_nx;
	ean8_pkg::win_t              win;
	logic                        fire;

	assign in_ready = !valid_s1 || evt_ready;
	assign accept   = in_valid && in_ready;

	assign w        = (module_width == '0) ? ean8_pkg::CNT_W'(1) : module_width;
	assign in_lead  = lead_count_q < lead_pixels;
	assign sum_nx   = sum_q + ean8_pkg::CNT_W'(pixel);
	assign pim_nx   = pim_q + ean8_pkg::CNT_W'(1);
	assign mod_done = !in_lead && (pim_nx >= w);
	assign mod_bit  = sum_nx > (w >> 1);
	assign pat_nx   = {pat_q[ean8_pkg::PAT_W-2:0], mod_bit};
	assign win      = ean8_pkg::digit_end(index_q);
	assign fire     = accept && mod_done && win.hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_count_q <= '0;
			pim_q        <= '0;
			sum_q        <= '0;
			index_q      <= '0;
			pat_q        <= '0;
		end else if (accept) begin
			if (row_end) begin
				lead_count_q <= '0;
				pim_q        <= '0;
				sum_q        <= '0;
				index_q      <= '0;
				pat_q        <= '0;
			end else if (in_lead) begin
				lead_count_q <= lead_count_q + ean8_pkg::LEAD_W'(1);
			end else if (mod_done) begin
				pim_q <= '0;
				sum_q <= '0;
				pat_q <= pat_nx;
				if (index_q != ean8_pkg::IDX_MAX) begin
					index_q <= index_q + ean8_pkg::IDX_W'(1);
				end
			end else begin
				pim_q <= pim_nx;
				sum_q <= sum_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (fire) begin
			valid_s1 <= 1'b1;
		end else if (evt_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			evt_s1.pattern  <= pat_nx;
			evt_s1.position <= win.position;
		end
	end

	assign evt_valid = valid_s1;
	assign evt       = evt_s1;

endmodule

FILE: hdl/ean8_digit_decode.sv
// Table match of a finished 7-module pattern and the result register.
// Depends on ean8_pkg.
module ean8_digit_decode (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          evt_valid,
	output logic                          evt_ready,
	input  ean8_pkg::evt_t                evt,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ean8_pkg::DIGIT_W-1:0]  digit,
	output logic [ean8_pkg::POS_W-1:0]    position,
	output logic                          matched,
	output logic                          last_digit
);

	logic                         valid_q;
	logic [ean8_pkg::DIGIT_W-1:0] digit_q;
	logic [ean8_pkg::POS_W-1:0]   position_q;
	logic                         matched_q;
	logic                         last_q;
	ean8_pkg::dec_t               dec;
	logic                         load;

	assign evt_ready = !valid_q || out_ready;
	assign load      = evt_valid && evt_ready;
	// The top position bit selects the right half and its R-code table.
	assign dec       = ean8_pkg::lookup(evt.pattern, evt.position[ean8_pkg::POS_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			digit_q    <= dec.digit;
			matched_q  <= dec.matched;
			position_q <= evt.position;
			last_q     <= evt.position == ean8_pkg::POS_LAST;
		end
	end

	assign out_valid  = valid_q;
	assign digit      = digit_q;
	assign position   = position_q;
	assign matched    = matched_q;
	assign last_digit = last_q;

endmodule

FILE: hdl/ean8_row_scanner.sv
// Top level of the EAN-8 row scanner: configuration port, framer and decoder.
// Depends on ean8_pkg, ean8_apb_regs, ean8_module_framer and ean8_digit_decode.
//
// The scanner takes one pixel of an image row per input transfer (1 for a
// black bar, 0 for white space) and returns one result transfer for each
// EAN-8 data digit it sees. After lead_pixels pixels are skipped, pixels are
// grouped into modules of module_width pixels (a width of zero acts as one),
// and a module reads as black when its black-pixel count exceeds half the
// width, rounded down. Modules 3 to 30 carry four L-coded digits and modules
// 36 to 63 four R-coded digits; each digit is reported with its position,
// a matched flag (digit is 0 when the pattern is not in its half's table) and a
// last_digit flag on position 7. A pixel that carries row_end clears all row
// counters; a digit window that it closes is still reported, but a partial
// module at that point is dropped. The block accepts one pixel every clock
// cycle while in_ready is high: counters update in the cycle of the transfer, a
// finished digit window sits in one stage register, and the table match
// feeds the result register. in_ready only
// drops when both the stage register and the result register are full and
// out_ready is low. Configuration is written through the APB-style port at
// byte address 0 (module_width) and 4 (lead_pixels) while the block is idle.
module ean8_row_scanner (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          pixel,
	input  logic                          row_end,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ean8_pkg::DIGIT_W-1:0]  digit,
	output logic [ean8_pkg::POS_W-1:0]    position,
	output logic                          matched,
	output logic                          last_digit
);

	logic [ean8_pkg::CNT_W-1:0]  module_width;
	logic [ean8_pkg::LEAD_W-1:0] lead_pixels;
	logic                        evt_valid;
	logic                        evt_ready;
	ean8_pkg::evt_t              evt;

	ean8_apb_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.module_width (module_width),
		.lead_pixels  (lead_pixels)
	);

	// Counts lead pixels and module pixels, and captures each finished
	// digit window together with its position.
	ean8_module_framer u_framer (
		.clk          (clk),
		.arst_n       (arst_n),
		.module_width (module_width),
		.lead_pixels  (lead_pixels),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel        (pixel),
		.row_end      (row_end),
		.evt_valid    (evt_valid),
		.evt_ready    (evt_ready),
		.evt          (evt)
	);

	// Matches the window against the L or R table and holds the result
	// until the output transfer completes.
	ean8_digit_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.evt_valid  (evt_valid),
		.evt_ready  (evt_ready),
		.evt        (evt),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.digit      (digit),
		.position   (position),
		.matched    (matched),
		.last_digit (last_digit)
	);

endmodule
